@@ sv/frustum_fov_widen_core_assert.svh @@
// ----------------------------------------------------------------------------
// frustum fov widen core assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_FOV_WIDEN_CORE_ASSERT_SVH
`define FRUSTUM_FOV_WIDEN_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FWC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fwc check failed");
`define FWC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fwc check failed");
`else
`define FWC_ASSERT_IMP(lbl, ante, cons)
`define FWC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/fwc_pkg.sv @@
// ----------------------------------------------------------------------------
// fwc_pkg
// shared constants, stage word types and the cordic angle table
// ----------------------------------------------------------------------------
package fwc_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int COORD_WIDTH  = 32;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CW           = 33;
  localparam int DIV_BITS     = 24;
  localparam int DIV_W        = $clog2(DIV_BITS);
  localparam int NLO_W        = DIV_BITS - 16;
  localparam int NLO_IW       = $clog2(NLO_W);
  localparam int SAT_W        = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  localparam logic [14:0] MUL_LO  = 15'd16384;
  localparam logic [14:0] MUL_HI  = 15'd24576;
  localparam logic [15:0] ONE_Q12 = 16'd4096;
  localparam logic [23:0] ONE_Q16 = 24'd65536;
  localparam logic [23:0] FOV_MAX = 24'hFFFFFF;
  localparam logic signed [CW-1:0] HALF_FOV_CAP = 33'sd1667889411;
  localparam logic [CW-1:0] ATAN_ONE = 33'h040000000;
  localparam logic signed [63:0] COORD_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] COORD_LO = -COORD_HI - 64'sd1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic               persp;
    logic               widen;
    logic               yzero;
    logic               sat;
    logic signed [31:0] l;
    logic signed [31:0] r;
    logic signed [31:0] b;
    logic signed [31:0] t;
    logic [29:0]        xn;
    logic [29:0]        yn;
  } side_t;

  typedef struct packed {
    logic [61:0]         rem;
    logic [61:0]         den;
    logic [DIV_BITS-1:0] q;
    logic [NLO_W-1:0]    nlo;
  } div_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [CW-1:0] a;
    case (i)
      0:       a = 33'sd843314857;
      1:       a = 33'sd497837829;
      2:       a = 33'sd263043837;
      3:       a = 33'sd133525159;
      4:       a = 33'sd67021687;
      5:       a = 33'sd33543516;
      6:       a = 33'sd16775851;
      7:       a = 33'sd8388437;
      8:       a = 33'sd4194283;
      9:       a = 33'sd2097149;
      default: a = $signed(ATAN_ONE >> i);
    endcase
    return a;
  endfunction

endpackage

@@ sv/fwc_vec_cell.sv @@
// ----------------------------------------------------------------------------
// fwc_vec_cell
// one cordic vectoring micro-rotation, registered, with its side word
// ----------------------------------------------------------------------------
module fwc_vec_cell import fwc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [STEP_W-1:0] step,
  input  logic              vld_i,
  input  cordic_t           cd_i,
  input  side_t             sd_i,
  output logic              vld_o,
  output cordic_t           cd_o,
  output side_t             sd_o
);

  logic                 vld_r;
  cordic_t              cd_r, cd_nxt;
  side_t                sd_r;
  logic signed [CW-1:0] xs, ys, ang;

  always_comb begin
    xs  = cd_i.x >>> step;
    ys  = cd_i.y >>> step;
    ang = atan_q30(step);
    if (cd_i.y > 0) begin
      cd_nxt.x = cd_i.x + ys;
      cd_nxt.y = cd_i.y - xs;
      cd_nxt.z = cd_i.z + ang;
    end else begin
      cd_nxt.x = cd_i.x - ys;
      cd_nxt.y = cd_i.y + xs;
      cd_nxt.z = cd_i.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    cd_r <= cd_nxt;
    sd_r <= sd_i;
  end

  assign vld_o = vld_r;
  assign cd_o  = cd_r;
  assign sd_o  = sd_r;

endmodule

@@ sv/fwc_rot_cell.sv @@
// ----------------------------------------------------------------------------
// fwc_rot_cell
// one cordic rotation micro-rotation, registered, with its side word
// ----------------------------------------------------------------------------
module fwc_rot_cell import fwc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [STEP_W-1:0] step,
  input  logic              vld_i,
  input  cordic_t           cd_i,
  input  side_t             sd_i,
  output logic              vld_o,
  output cordic_t           cd_o,
  output side_t             sd_o
);

  logic                 vld_r;
  cordic_t              cd_r, cd_nxt;
  side_t                sd_r;
  logic signed [CW-1:0] xs, ys, ang;

  always_comb begin
    xs  = cd_i.x >>> step;
    ys  = cd_i.y >>> step;
    ang = atan_q30(step);
    if (cd_i.z >= 0) begin
      cd_nxt.x = cd_i.x - ys;
      cd_nxt.y = cd_i.y + xs;
      cd_nxt.z = cd_i.z - ang;
    end else begin
      cd_nxt.x = cd_i.x + ys;
      cd_nxt.y = cd_i.y - xs;
      cd_nxt.z = cd_i.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    cd_r <= cd_nxt;
    sd_r <= sd_i;
  end

  assign vld_o = vld_r;
  assign cd_o  = cd_r;
  assign sd_o  = sd_r;

endmodule

@@ sv/fwc_div_cell.sv @@
// ----------------------------------------------------------------------------
// fwc_div_cell
// one restoring division step, one quotient bit, registered
// ----------------------------------------------------------------------------
module fwc_div_cell import fwc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DIV_W-1:0] step,
  input  logic             vld_i,
  input  div_t             dv_i,
  input  side_t            sd_i,
  output logic             vld_o,
  output div_t             dv_o,
  output side_t            sd_o
);

  logic        vld_r;
  div_t        dv_r, dv_nxt;
  side_t       sd_r;
  logic        nbit;
  logic [62:0] trial;
  logic [63:0] diff;

  always_comb begin
    nbit  = (step >= DIV_W'(16)) ? dv_i.nlo[NLO_IW'(step - DIV_W'(16))] : 1'b0;
    trial = {dv_i.rem, nbit};
    diff  = {1'b0, trial} - {2'b00, dv_i.den};
    dv_nxt     = dv_i;
    if (!diff[63]) begin
      dv_nxt.rem = diff[61:0];
      dv_nxt.q   = {dv_i.q[DIV_BITS-2:0], 1'b1};
    end else begin
      dv_nxt.rem = trial[61:0];
      dv_nxt.q   = {dv_i.q[DIV_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    dv_r <= dv_nxt;
    sd_r <= sd_i;
  end

  assign vld_o = vld_r;
  assign dv_o  = dv_r;
  assign sd_o  = sd_r;

endmodule

@@ sv/frustum_fov_widen_core.sv @@
// ----------------------------------------------------------------------------
// frustum_fov_widen_core
// throughput one word per cycle, busy is never raised; the cordic, divider
// and scaling chains are fully pipelined, one cell per register stage
// out_valid is a one-cycle strobe, the receiver cannot stall
// rst_n (synchronous) empties the pipeline and loads register defaults
// ----------------------------------------------------------------------------
`include "frustum_fov_widen_core_assert.svh"
module frustum_fov_widen_core import fwc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_is_perspective,
  input  logic signed [31:0] in_edge_left,
  input  logic signed [31:0] in_edge_right,
  input  logic signed [31:0] in_edge_bottom,
  input  logic signed [31:0] in_edge_top,
  input  logic signed [31:0] in_near_dist,
  output logic               out_valid,
  output logic signed [31:0] out_left,
  output logic signed [31:0] out_right,
  output logic signed [31:0] out_bottom,
  output logic signed [31:0] out_top,
  output logic [23:0]        out_fov_scale,
  output logic [27:0]        out_horiz_scale,
  output logic [27:0]        out_vert_scale,
  output logic               out_applied,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [1:0] REG_FOV_MUL   = 2'd0;
  localparam logic [1:0] REG_HORIZ_EXP = 2'd1;
  localparam logic [1:0] REG_VERT_EXP  = 2'd2;

  // configuration registers
  logic [14:0] mul_r;
  logic [15:0] hexp_r, vexp_r;
  logic [14:0] m_c;
  logic [15:0] he_c, ve_c;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= MUL_LO;
      hexp_r <= ONE_Q12;
      vexp_r <= ONE_Q12;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FOV_MUL:   mul_r  <= pwdata[14:0];
        REG_HORIZ_EXP: hexp_r <= pwdata[15:0];
        REG_VERT_EXP:  vexp_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FOV_MUL:   prdata = {17'b0, mul_r};
      REG_HORIZ_EXP: prdata = {16'b0, hexp_r};
      REG_VERT_EXP:  prdata = {16'b0, vexp_r};
      default:       prdata = 32'b0;
    endcase
  end

  assign m_c  = (mul_r < MUL_LO) ? MUL_LO : ((mul_r > MUL_HI) ? MUL_HI : mul_r);
  assign he_c = (hexp_r < ONE_Q12) ? ONE_Q12 : hexp_r;
  assign ve_c = (vexp_r < ONE_Q12) ? ONE_Q12 : vexp_r;

  // stage 1: capture, twice the near distance and the vertical extent
  logic        s1_vld_r;
  side_t       s1_sd_r, s1_sd_nxt;
  logic [32:0] s1_hn_r, s1_hd_r, s1_hn_nxt, s1_hd_nxt;
  logic [31:0] n_abs;
  logic signed [32:0] dtb;

  always_comb begin
    n_abs     = in_near_dist[31] ? 32'(-in_near_dist) : 32'(in_near_dist);
    dtb       = {in_edge_top[31], in_edge_top} - {in_edge_bottom[31], in_edge_bottom};
    s1_hn_nxt = {n_abs, 1'b0};
    s1_hd_nxt = dtb[32] ? 33'(-dtb) : 33'(dtb);
    s1_sd_nxt.persp = in_is_perspective;
    s1_sd_nxt.widen = in_is_perspective && (in_near_dist != 32'sd0) &&
                      (in_edge_top != in_edge_bottom) && (m_c > MUL_LO);
    s1_sd_nxt.yzero = 1'b0;
    s1_sd_nxt.sat   = 1'b0;
    s1_sd_nxt.l     = in_edge_left;
    s1_sd_nxt.r     = in_edge_right;
    s1_sd_nxt.b     = in_edge_bottom;
    s1_sd_nxt.t     = in_edge_top;
    s1_sd_nxt.xn    = 30'b0;
    s1_sd_nxt.yn    = 30'b0;
  end

  // stage 2: leading one of the pair
  logic        s2_vld_r;
  side_t       s2_sd_r;
  logic [32:0] s2_hn_r, s2_hd_r, lead_v;
  logic [5:0]  s2_pos_r, s2_pos_nxt;

  always_comb begin
    lead_v     = s1_hn_r | s1_hd_r;
    s2_pos_nxt = 6'd0;
    for (int k = 0; k < 33; k++) begin
      if (lead_v[k]) s2_pos_nxt = 6'(k);
    end
  end

  // stage 3: joint normalisation into [2^29, 2^30)
  logic        s3_vld_r;
  side_t       s3_sd_r, s3_sd_nxt;
  cordic_t     s3_cd_r, s3_cd_nxt;
  logic [32:0] xs_n, ys_n;

  always_comb begin
    if (s2_pos_r > 6'd29) begin
      xs_n = s2_hn_r >> (s2_pos_r - 6'd29);
      ys_n = s2_hd_r >> (s2_pos_r - 6'd29);
    end else begin
      xs_n = s2_hn_r << (6'd29 - s2_pos_r);
      ys_n = s2_hd_r << (6'd29 - s2_pos_r);
    end
    s3_sd_nxt       = s2_sd_r;
    s3_sd_nxt.xn    = xs_n[29:0];
    s3_sd_nxt.yn    = ys_n[29:0];
    s3_sd_nxt.yzero = (ys_n[29:0] == 30'b0);
    s3_cd_nxt.x     = $signed({3'b000, xs_n[29:0]});
    s3_cd_nxt.y     = $signed({3'b000, ys_n[29:0]});
    s3_cd_nxt.z     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start & ~busy;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_sd_r  <= s1_sd_nxt;
    s1_hn_r  <= s1_hn_nxt;
    s1_hd_r  <= s1_hd_nxt;
    s2_sd_r  <= s1_sd_r;
    s2_hn_r  <= s1_hn_r;
    s2_hd_r  <= s1_hd_r;
    s2_pos_r <= s2_pos_nxt;
    s3_sd_r  <= s3_sd_nxt;
    s3_cd_r  <= s3_cd_nxt;
  end

  // vectoring chain: base half angle
  logic    vec_vld [CORDIC_STEPS+1];
  cordic_t vec_cd  [CORDIC_STEPS+1];
  side_t   vec_sd  [CORDIC_STEPS+1];

  assign vec_vld[0] = s3_vld_r;
  assign vec_cd[0]  = s3_cd_r;
  assign vec_sd[0]  = s3_sd_r;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    fwc_vec_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (STEP_W'(k)),
      .vld_i (vec_vld[k]),
      .cd_i  (vec_cd[k]),
      .sd_i  (vec_sd[k]),
      .vld_o (vec_vld[k+1]),
      .cd_o  (vec_cd[k+1]),
      .sd_o  (vec_sd[k+1])
    );
  end

  // widened angle: product, then cap
  logic        mz_vld_r;
  side_t       mz_sd_r;
  logic [46:0] mz_prod_r, mz_prod_nxt;
  logic [31:0] zc;
  logic        tc_vld_r;
  side_t       tc_sd_r;
  cordic_t     tc_cd_r, tc_cd_nxt;
  logic signed [CW-1:0] t_ang;

  always_comb begin
    zc          = (vec_cd[CORDIC_STEPS].z < 0) ? 32'b0 : vec_cd[CORDIC_STEPS].z[31:0];
    mz_prod_nxt = 47'(zc) * 47'(m_c);
    t_ang       = $signed(mz_prod_r[46:14]);
    tc_cd_nxt.x = 33'sd536870912;
    tc_cd_nxt.y = '0;
    tc_cd_nxt.z = (t_ang > HALF_FOV_CAP) ? HALF_FOV_CAP : t_ang;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mz_vld_r <= 1'b0;
      tc_vld_r <= 1'b0;
    end else begin
      mz_vld_r <= vec_vld[CORDIC_STEPS];
      tc_vld_r <= mz_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    mz_sd_r   <= vec_sd[CORDIC_STEPS];
    mz_prod_r <= mz_prod_nxt;
    tc_sd_r   <= mz_sd_r;
    tc_cd_r   <= tc_cd_nxt;
  end

  // rotation chain: tan of the target angle
  logic    rot_vld [CORDIC_STEPS+1];
  cordic_t rot_cd  [CORDIC_STEPS+1];
  side_t   rot_sd  [CORDIC_STEPS+1];

  assign rot_vld[0] = tc_vld_r;
  assign rot_cd[0]  = tc_cd_r;
  assign rot_sd[0]  = tc_sd_r;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    fwc_rot_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (STEP_W'(k)),
      .vld_i (rot_vld[k]),
      .cd_i  (rot_cd[k]),
      .sd_i  (rot_sd[k]),
      .vld_o (rot_vld[k+1]),
      .cd_o  (rot_cd[k+1]),
      .sd_o  (rot_sd[k+1])
    );
  end

  // ratio operands
  logic        nd_vld_r;
  side_t       nd_sd_r, nd_sd_nxt;
  logic [61:0] nd_num_r, nd_den_r, nd_num_nxt, nd_den_nxt;
  logic [31:0] yc, xc;
  cordic_t     rot_end;

  always_comb begin
    rot_end       = rot_cd[CORDIC_STEPS];
    yc            = (rot_end.y < 0) ? 32'b0 : rot_end.y[31:0];
    xc            = rot_end.x[31:0];
    nd_num_nxt    = 62'(yc) * 62'(rot_sd[CORDIC_STEPS].xn);
    nd_den_nxt    = 62'(xc) * 62'(rot_sd[CORDIC_STEPS].yn);
    nd_sd_nxt     = rot_sd[CORDIC_STEPS];
    nd_sd_nxt.sat = (rot_end.x <= 0);
  end

  // divider set-up: integer part range check
  logic  d0_vld_r;
  side_t d0_sd_r, d0_sd_nxt;
  div_t  d0_dv_r, d0_dv_nxt;

  always_comb begin
    d0_dv_nxt.rem = {8'b0, nd_num_r[61:8]};
    d0_dv_nxt.den = nd_den_r;
    d0_dv_nxt.q   = '0;
    d0_dv_nxt.nlo = nd_num_r[NLO_W-1:0];
    d0_sd_nxt     = nd_sd_r;
    d0_sd_nxt.sat = nd_sd_r.sat | ({8'b0, nd_num_r[61:8]} >= nd_den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nd_vld_r <= 1'b0;
      d0_vld_r <= 1'b0;
    end else begin
      nd_vld_r <= rot_vld[CORDIC_STEPS];
      d0_vld_r <= nd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    nd_sd_r  <= nd_sd_nxt;
    nd_num_r <= nd_num_nxt;
    nd_den_r <= nd_den_nxt;
    d0_sd_r  <= d0_sd_nxt;
    d0_dv_r  <= d0_dv_nxt;
  end

  // division chain, quotient msb first
  logic  div_vld [DIV_BITS+1];
  div_t  div_dv  [DIV_BITS+1];
  side_t div_sd  [DIV_BITS+1];

  assign div_vld[0] = d0_vld_r;
  assign div_dv[0]  = d0_dv_r;
  assign div_sd[0]  = d0_sd_r;

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    fwc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (DIV_W'(DIV_BITS - 1 - k)),
      .vld_i (div_vld[k]),
      .dv_i  (div_dv[k]),
      .sd_i  (div_sd[k]),
      .vld_o (div_vld[k+1]),
      .dv_o  (div_dv[k+1]),
      .sd_o  (div_sd[k+1])
    );
  end

  // fov scale
  logic        fs_vld_r;
  side_t       fs_sd_r, div_end_sd;
  logic [23:0] fs_r, fs_nxt, qv;

  always_comb begin
    div_end_sd = div_sd[DIV_BITS];
    qv         = div_dv[DIV_BITS].q;
    if (!div_end_sd.persp || !div_end_sd.widen) fs_nxt = ONE_Q16;
    else if (div_end_sd.yzero) fs_nxt = {7'b0, m_c, 2'b00};
    else if (div_end_sd.sat) fs_nxt = FOV_MAX;
    else if (qv < ONE_Q16) fs_nxt = ONE_Q16;
    else fs_nxt = qv;
  end

  // axis scales
  logic        hs_vld_r;
  side_t       hs_sd_r;
  logic [23:0] hs_fs_r;
  logic [27:0] hs_h_r, hs_v_r, hs_h_nxt, hs_v_nxt;
  logic [39:0] hprod, vprod;

  always_comb begin
    hprod    = 40'(fs_r) * 40'(he_c);
    vprod    = 40'(fs_r) * 40'(ve_c);
    hs_h_nxt = fs_sd_r.persp ? hprod[39:12] : 28'(ONE_Q16);
    hs_v_nxt = fs_sd_r.persp ? vprod[39:12] : 28'(ONE_Q16);
  end

  // edge span products
  logic        ds_vld_r;
  side_t       ds_sd_r;
  logic [23:0] ds_fs_r;
  logic [27:0] ds_h_r, ds_v_r;
  logic signed [61:0] ds_hp_r, ds_vp_r, ds_hp_nxt, ds_vp_nxt;
  logic signed [32:0] dh, dv;

  always_comb begin
    dh        = {hs_sd_r.l[31], hs_sd_r.l} - {hs_sd_r.r[31], hs_sd_r.r};
    dv        = {hs_sd_r.b[31], hs_sd_r.b} - {hs_sd_r.t[31], hs_sd_r.t};
    ds_hp_nxt = dh * $signed({1'b0, hs_h_r});
    ds_vp_nxt = dv * $signed({1'b0, hs_v_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_vld_r <= 1'b0;
      hs_vld_r <= 1'b0;
      ds_vld_r <= 1'b0;
    end else begin
      fs_vld_r <= div_vld[DIV_BITS];
      hs_vld_r <= fs_vld_r;
      ds_vld_r <= hs_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    fs_sd_r <= div_end_sd;
    fs_r    <= fs_nxt;
    hs_sd_r <= fs_sd_r;
    hs_fs_r <= fs_r;
    hs_h_r  <= hs_h_nxt;
    hs_v_r  <= hs_v_nxt;
    ds_sd_r <= hs_sd_r;
    ds_fs_r <= hs_fs_r;
    ds_h_r  <= hs_h_r;
    ds_v_r  <= hs_v_r;
    ds_hp_r <= ds_hp_nxt;
    ds_vp_r <= ds_vp_nxt;
  end

  // rounding, saturation, output word
  function automatic logic signed [31:0] fwc_edge(input logic signed [31:0] lo,
                                                  input logic signed [31:0] hi,
                                                  input logic signed [61:0] ds,
                                                  input logic               neg);
    logic signed [32:0] s;
    logic signed [63:0] sum64, ds64, acc, sh;
    s     = {lo[31], lo} + {hi[31], hi};
    sum64 = {{15{s[32]}}, s, 16'b0};
    ds64  = {{2{ds[61]}}, ds};
    acc   = neg ? (sum64 - ds64 + 64'sd65536) : (sum64 + ds64 + 64'sd65536);
    sh    = acc >>> 17;
    if (sh > COORD_HI) sh = COORD_HI;
    else if (sh < COORD_LO) sh = COORD_LO;
    return sh[31:0];
  endfunction

  logic               out_valid_r, pass_h, pass_v, applied_nxt;
  logic signed [31:0] ol_r, or_r, ob_r, ot_r, ol_nxt, or_nxt, ob_nxt, ot_nxt;
  logic [23:0]        ofs_r;
  logic [27:0]        ohs_r, ovs_r;
  logic               oap_r;

  always_comb begin
    pass_h      = !ds_sd_r.persp || (ds_sd_r.l == ds_sd_r.r);
    pass_v      = !ds_sd_r.persp || (ds_sd_r.b == ds_sd_r.t);
    ol_nxt      = pass_h ? ds_sd_r.l : fwc_edge(ds_sd_r.l, ds_sd_r.r, ds_hp_r, 1'b0);
    or_nxt      = pass_h ? ds_sd_r.r : fwc_edge(ds_sd_r.l, ds_sd_r.r, ds_hp_r, 1'b1);
    ob_nxt      = pass_v ? ds_sd_r.b : fwc_edge(ds_sd_r.b, ds_sd_r.t, ds_vp_r, 1'b0);
    ot_nxt      = pass_v ? ds_sd_r.t : fwc_edge(ds_sd_r.b, ds_sd_r.t, ds_vp_r, 1'b1);
    applied_nxt = ds_sd_r.persp &&
                  (ds_sd_r.widen || (he_c != ONE_Q12) || (ve_c != ONE_Q12));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= ds_vld_r;
  end

  always_ff @(posedge clk) begin
    ol_r  <= ol_nxt;
    or_r  <= or_nxt;
    ob_r  <= ob_nxt;
    ot_r  <= ot_nxt;
    ofs_r <= ds_fs_r;
    ohs_r <= ds_h_r;
    ovs_r <= ds_v_r;
    oap_r <= applied_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_left        = ol_r;
  assign out_right       = or_r;
  assign out_bottom      = ob_r;
  assign out_top         = ot_r;
  assign out_fov_scale   = ofs_r;
  assign out_horiz_scale = ohs_r;
  assign out_vert_scale  = ovs_r;
  assign out_applied     = oap_r;

  `FWC_ASSERT_NXT(a_strobe_follows, ds_vld_r, out_valid)
  `FWC_ASSERT_NXT(a_no_spurious_word, !ds_vld_r, !out_valid)
  `FWC_ASSERT_IMP(a_fov_floor, out_valid, out_fov_scale >= ONE_Q16)
  `FWC_ASSERT_IMP(a_widen_flagged, out_valid && (out_fov_scale != ONE_Q16), out_applied)
  `FWC_ASSERT_IMP(a_horiz_floor, out_valid, out_horiz_scale >= 28'(ONE_Q16))

endmodule
